// File: rtl/baro_pkg.sv
// Shared types, constants and helper functions of the barometer compensation block.
package baro_pkg;

   localparam int AVG_DEPTH = 64;
   localparam int PTR_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int PRES_W    = 20;
   localparam int SUM_W     = PRES_W + PTR_W;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 2;

   localparam logic [PRES_W-1:0] PRES_MAX = {PRES_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_C = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OSS   = 2'd3;

   localparam logic OP_TEMP  = 1'b0;
   localparam logic OP_PRESS = 1'b1;

   // formula constants
   localparam logic [31:0] K_4000  = 32'd4000;
   localparam logic [31:0] K_32768 = 32'd32768;
   localparam logic [31:0] K_50000 = 32'd50000;
   localparam logic [31:0] K_3038  = 32'd3038;
   localparam logic [31:0] K_M7357 = 32'hFFFF_E343;  // -7357
   localparam logic [31:0] K_3791  = 32'd3791;

   // datapath step codes
   typedef enum logic [4:0] {
      ST_IDLE, ST_T_X1, ST_T_DIV, ST_T_FIN,
      ST_P_SQ, ST_P_X1, ST_P_X3, ST_P_B3, ST_P_X3B, ST_P_B4, ST_P_B7,
      ST_P_DIV, ST_P_Q, ST_P_PP, ST_P_X1C, ST_P_X3C, ST_P_FIN, ST_WAIT
   } step_type;

   typedef struct packed {
      step_type step;
      logic     load;
      logic     commit;
   } cmd_type;

   typedef struct packed {
      logic req_op;
      logic div_idle;
      logic out_busy;
   } stat_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
      return $unsigned($signed(x) >>> n);
   endfunction

endpackage

// File: rtl/baro_ifs.sv
// Request and response channel interfaces.
interface baro_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [23:0] raw_reading;
   modport source (output valid, operation, raw_reading, input ready);
   modport sink   (input valid, operation, raw_reading, output ready);
endinterface

interface baro_rsp_if;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic signed [15:0] temperature_tenths;
   logic [19:0]        pressure_pa;
   logic [19:0]        pressure_avg_pa;
   logic               divide_fault;
   modport source (output valid, result_kind, temperature_tenths, pressure_pa,
                   pressure_avg_pa, divide_fault, input ready);
   modport sink   (input valid, result_kind, temperature_tenths, pressure_pa,
                   pressure_avg_pa, divide_fault, output ready);
endinterface

// File: rtl/baro_dp.sv
// Datapath: calibration registers, shared multiplier, serial divider, pressure ring.
module baro_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [baro_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [baro_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                          req_operation,
   input  logic [23:0]                   req_raw_reading,
   input  baro_pkg::cmd_type             cmd,
   output baro_pkg::stat_type            stat,
   baro_rsp_if.source                    rsp
);
   import baro_pkg::*;

   logic [63:0] cal_a_ff, cal_b_ff;
   logic [31:0] cal_c_ff;
   logic [1:0]  oss_ff;

   logic        op_ff;
   logic [23:0] raw_ff;
   logic [31:0] tt_ff, b6_ff, sq_ff, x1_ff, x3_ff, b3_ff, b4_ff, b7_ff, p_ff, up_ff;
   logic        pflag_ff, fault_ff;

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   logic [31:0] ma, mb, prod;
   logic [63:0] prod_full;

   // divider
   logic [31:0] dvs_ff, quo_ff, rem_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff, negq_ff;
   logic [32:0] shifted;
   logic        qbit;
   logic [31:0] quot;

   // ring
   logic [PRES_W-1:0] ring_mem [AVG_DEPTH];
   logic [AVG_DEPTH-1:0] ring_vld_ff;
   logic [PRES_W-1:0] ring_rd_ff;
   logic              ring_rd_vld_ff;
   logic [PTR_W-1:0]  ptr_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PRES_W-1:0] old_val;

   logic [31:0] tt_new, tq, pf, bv, dvd_t, dvd_p, den;
   logic [PRES_W-1:0] pout;
   logic [15:0] tout;

   logic              rsp_valid_ff;
   logic              rsp_kind_ff, rsp_fault_ff;
   logic [15:0]       rsp_temp_ff;
   logic [PRES_W-1:0] rsp_p_ff, rsp_avg_ff;

   // calibration field decode
   assign ac1 = sx16(cal_a_ff[63:48]);
   assign ac2 = sx16(cal_a_ff[47:32]);
   assign ac3 = sx16(cal_a_ff[31:16]);
   assign ac4 = {16'd0, cal_a_ff[15:0]};
   assign ac5 = {16'd0, cal_b_ff[63:48]};
   assign ac6 = {16'd0, cal_b_ff[47:32]};
   assign b1  = sx16(cal_b_ff[31:16]);
   assign b2  = sx16(cal_b_ff[15:0]);
   assign mc  = sx16(cal_c_ff[31:16]);
   assign md  = sx16(cal_c_ff[15:0]);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_c_ff <= '0;
         oss_ff   <= 2'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAL_A: cal_a_ff <= csr_wdata;
            CSR_CAL_B: cal_b_ff <= csr_wdata;
            CSR_CAL_C: cal_c_ff <= csr_wdata[31:0];
            CSR_OSS:   oss_ff   <= csr_wdata[1:0];
            default:   ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.step)
         ST_T_X1:  begin ma = {16'd0, raw_ff[15:0]} - ac6; mb = ac5; end
         ST_P_SQ:  begin ma = tt_ff - K_4000; mb = tt_ff - K_4000; end
         ST_P_X1:  begin ma = b2; mb = sq_ff; end
         ST_P_X3:  begin ma = ac2; mb = b6_ff; end
         ST_P_B3:  begin ma = ac3; mb = b6_ff; end
         ST_P_X3B: begin ma = b1; mb = sq_ff; end
         ST_P_B4:  begin ma = ac4; mb = x3_ff + K_32768; end
         ST_P_B7:  begin ma = up_ff - b3_ff; mb = K_50000 >> oss_ff; end
         ST_P_PP:  begin ma = asr(p_ff, 5'd8); mb = asr(p_ff, 5'd8); end
         ST_P_X1C: begin ma = x1_ff; mb = K_3038; end
         ST_P_X3C: begin ma = K_M7357; mb = p_ff; end
         default:  ;
      endcase
   end
   assign prod_full = ma * mb;
   assign prod      = prod_full[31:0];

   // b3 = (((ac1*4 + x3) << oss) + 2) / 4, truncating toward zero
   assign bv = (((ac1 << 2) + x3_ff) << oss_ff) + 32'd2;

   // divider operands
   assign den   = x1_ff + md;
   assign dvd_t = mc << 11;
   assign dvd_p = b7_ff[31] ? b7_ff : (b7_ff << 1);

   // restoring divider step
   assign shifted = {rem_ff, quo_ff[31]};
   assign qbit    = (shifted >= {1'b0, dvs_ff});
   assign quot    = negq_ff ? (32'd0 - quo_ff) : quo_ff;

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_operation;
         raw_ff <= req_raw_reading;
      end
      case (cmd.step)
         ST_T_X1:  x1_ff <= asr(prod, 5'd15);
         ST_T_DIV: fault_ff <= (den == 32'd0);
         ST_P_SQ: begin
            b6_ff <= tt_ff - K_4000;
            sq_ff <= asr(prod, 5'd12);
            up_ff <= {8'd0, raw_ff >> (4'd8 - {2'b00, oss_ff})};
         end
         ST_P_X1:  x1_ff <= asr(prod, 5'd11);
         ST_P_X3:  x3_ff <= x1_ff + asr(prod, 5'd11);
         ST_P_B3: begin
            b3_ff <= bv[31] ? asr(bv + 32'd3, 5'd2) : asr(bv, 5'd2);
            x1_ff <= asr(prod, 5'd13);
         end
         ST_P_X3B: x3_ff <= asr(x1_ff + asr(prod, 5'd16) + 32'd2, 5'd2);
         ST_P_B4:  b4_ff <= prod >> 15;
         ST_P_B7:  b7_ff <= prod;
         ST_P_DIV: begin
            pflag_ff <= b7_ff[31];
            fault_ff <= (b4_ff == 32'd0);
         end
         ST_P_Q:   p_ff  <= pflag_ff ? (quot << 1) : quot;
         ST_P_PP:  x1_ff <= prod;
         ST_P_X1C: x1_ff <= asr(prod, 5'd16);
         ST_P_X3C: x3_ff <= x1_ff + asr(prod, 5'd16) + K_3791;
         default:  ;
      endcase
   end

   // serial divider, one quotient bit per cycle; temperature operands are taken as magnitudes
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.step == ST_T_DIV || cmd.step == ST_P_DIV) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == 5'd31) begin
         busy_ff <= 1'b0;
      end
      if (cmd.step == ST_T_DIV) begin
         quo_ff  <= dvd_t[31] ? (32'd0 - dvd_t) : dvd_t;
         dvs_ff  <= den[31] ? (32'd0 - den) : den;
         negq_ff <= dvd_t[31] ^ den[31];
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end else if (cmd.step == ST_P_DIV) begin
         quo_ff  <= dvd_p;
         dvs_ff  <= b4_ff;
         negq_ff <= 1'b0;
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff <= qbit ? 32'(shifted - {1'b0, dvs_ff}) : shifted[31:0];
         quo_ff <= {quo_ff[30:0], qbit};
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

   // temperature finish
   assign tt_new = fault_ff ? 32'd0 : x1_ff + quot;
   assign tq     = asr(tt_new + 32'd8, 5'd4);
   always_comb begin
      if ($signed(tq) > 32'sd32767)       tout = 16'h7FFF;
      else if ($signed(tq) < -32'sd32768) tout = 16'h8000;
      else                                tout = tq[15:0];
   end

   // pressure finish
   assign pf = p_ff + asr(x3_ff, 5'd4);
   always_comb begin
      if (fault_ff || pf[31])              pout = '0;
      else if (pf > {12'd0, PRES_MAX})     pout = PRES_MAX;
      else                                 pout = pf[PRES_W-1:0];
   end

   // ring: registered read at the pointer, entries not yet written read as zero
   assign old_val = ring_rd_vld_ff ? ring_rd_ff : '0;
   assign sum_in  = sum_ff - SUM_W'(old_val) + SUM_W'(pout);

   always_ff @(posedge clock) begin
      ring_rd_ff <= ring_mem[ptr_ff];
      if (cmd.commit && op_ff == OP_PRESS) ring_mem[ptr_ff] <= pout;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff    <= '0;
         ring_rd_vld_ff <= 1'b0;
         ptr_ff         <= '0;
         sum_ff         <= '0;
         tt_ff          <= '0;
      end else begin
         ring_rd_vld_ff <= ring_vld_ff[ptr_ff];
         if (cmd.commit && op_ff == OP_PRESS) begin
            ring_vld_ff[ptr_ff] <= 1'b1;
            sum_ff <= sum_in;
            ptr_ff <= (ptr_ff == PTR_W'(AVG_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
         end
         if (cmd.commit && op_ff == OP_TEMP) tt_ff <= tt_new;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.commit) begin
         rsp_kind_ff  <= op_ff;
         rsp_fault_ff <= fault_ff;
         if (op_ff == OP_TEMP) begin
            rsp_temp_ff <= tout;
            rsp_p_ff    <= '0;
            rsp_avg_ff  <= PRES_W'(sum_ff / AVG_DEPTH);
         end else begin
            rsp_temp_ff <= '0;
            rsp_p_ff    <= pout;
            rsp_avg_ff  <= PRES_W'(sum_in / AVG_DEPTH);
         end
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.result_kind        = rsp_kind_ff;
   assign rsp.temperature_tenths = rsp_temp_ff;
   assign rsp.pressure_pa        = rsp_p_ff;
   assign rsp.pressure_avg_pa    = rsp_avg_ff;
   assign rsp.divide_fault       = rsp_fault_ff;

   assign stat.req_op   = req_operation;
   assign stat.div_idle = ~busy_ff;
   assign stat.out_busy = rsp_valid_ff & ~rsp.ready;

endmodule

// File: rtl/baro_ctrl.sv
// Sequencer that steps the datapath through the compensation formulas.
module baro_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  baro_pkg::stat_type stat,
   output baro_pkg::cmd_type  cmd
);
   import baro_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_T_X1, S_T_DIV, S_T_WAIT, S_T_FIN,
      S_P_SQ, S_P_X1, S_P_X3, S_P_B3, S_P_X3B, S_P_B4, S_P_B7,
      S_P_DIV, S_P_WAIT, S_P_Q, S_P_PP, S_P_X1C, S_P_X3C, S_P_FIN
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = (stat.req_op == OP_PRESS) ? S_P_SQ : S_T_X1;
         S_T_X1:   state_in = S_T_DIV;
         S_T_DIV:  state_in = S_T_WAIT;
         S_T_WAIT: if (stat.div_idle) state_in = S_T_FIN;
         S_T_FIN:  if (!stat.out_busy) state_in = S_IDLE;
         S_P_SQ:   state_in = S_P_X1;
         S_P_X1:   state_in = S_P_X3;
         S_P_X3:   state_in = S_P_B3;
         S_P_B3:   state_in = S_P_X3B;
         S_P_X3B:  state_in = S_P_B4;
         S_P_B4:   state_in = S_P_B7;
         S_P_B7:   state_in = S_P_DIV;
         S_P_DIV:  state_in = S_P_WAIT;
         S_P_WAIT: if (stat.div_idle) state_in = S_P_Q;
         S_P_Q:    state_in = S_P_PP;
         S_P_PP:   state_in = S_P_X1C;
         S_P_X1C:  state_in = S_P_X3C;
         S_P_X3C:  state_in = S_P_FIN;
         S_P_FIN:  if (!stat.out_busy) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command decode
   always_comb begin
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         S_IDLE:   begin cmd.step = ST_IDLE; cmd.load = req_valid; end
         S_T_X1:   cmd.step = ST_T_X1;
         S_T_DIV:  cmd.step = ST_T_DIV;
         S_T_FIN:  begin cmd.step = ST_T_FIN; cmd.commit = ~stat.out_busy; end
         S_P_SQ:   cmd.step = ST_P_SQ;
         S_P_X1:   cmd.step = ST_P_X1;
         S_P_X3:   cmd.step = ST_P_X3;
         S_P_B3:   cmd.step = ST_P_B3;
         S_P_X3B:  cmd.step = ST_P_X3B;
         S_P_B4:   cmd.step = ST_P_B4;
         S_P_B7:   cmd.step = ST_P_B7;
         S_P_DIV:  cmd.step = ST_P_DIV;
         S_P_Q:    cmd.step = ST_P_Q;
         S_P_PP:   cmd.step = ST_P_PP;
         S_P_X1C:  cmd.step = ST_P_X1C;
         S_P_X3C:  cmd.step = ST_P_X3C;
         S_P_FIN:  begin cmd.step = ST_P_FIN; cmd.commit = ~stat.out_busy; end
         default:  cmd.step = ST_WAIT;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// File: rtl/baro_compensation_averager.sv
// Top level: barometer temperature/pressure compensation with pressure ring average.
// Temperature request: one 32-step divide between accept and response.
// Pressure request: shared multiplier and one 32-step divide between accept and response.
// One request in flight; the next is taken the cycle after its response is registered.
// Synchronous active-high reset clears calibration (oversampling to 1), the stored
// temperature term, the ring valid bits, pointer and sum; ring entries read as zero.
module baro_compensation_averager (
   input  logic                           clock,
   input  logic                           reset,
   baro_req_if.sink                       req_ch,
   baro_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [baro_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [baro_pkg::CSR_W-1:0]     csr_wdata
);
   import baro_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   baro_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   baro_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_operation   (req_ch.operation),
      .req_raw_reading (req_ch.raw_reading),
      .cmd             (cmd),
      .stat            (stat),
      .rsp             (rsp_ch)
   );

endmodule

// File: rtl/baro_chk.sv
// Port-level checker for the compensation block, bound to the top level.
module baro_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [15:0] rsp_temp,
   input logic [19:0] rsp_p,
   input logic        rsp_fault
);

   // a response is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_p) && $stable(rsp_kind))
      else $error("response dropped or changed while stalled");

   // one request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

   // temperature responses carry no pressure
   a_temp_nopress: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_p == 20'd0)
      else $error("temperature response with pressure value");

   // a divide fault forces a zero result
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_p == 20'd0 && rsp_temp == 16'd0)
      else $error("divide fault with nonzero result");

endmodule

bind baro_compensation_averager baro_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_kind  (rsp_ch.result_kind),
   .rsp_temp  (rsp_ch.temperature_tenths),
   .rsp_p     (rsp_ch.pressure_pa),
   .rsp_fault (rsp_ch.divide_fault)
);

// File: dv/baro_compensation_averager_tb.sv
// Self-checking testbench of the barometer compensation and pressure averaging block.
module baro_compensation_averager_tb;
   import baro_pkg::*;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] temp;
      logic [19:0]        pres;
      logic [19:0]        avg;
      logic               fault;
   } reading_result_t;

   typedef struct {
      logic        op;
      logic [23:0] raw;
      logic        typed;
      reading_result_t res;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   baro_req_if req_ch ();
   baro_rsp_if rsp_ch ();

   baro_compensation_averager uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [63:0] cal_a, cal_b;
   logic [31:0] cal_c;
   logic [1:0]  oss_setting;
   logic [31:0] b5_term;
   logic [19:0] ring [AVG_DEPTH];
   int unsigned ring_ptr;
   logic [31:0] ring_total;

   reading_result_t expected_results[$];
   int errors = 0;
   int accepted = 0, temp_items = 0, pres_items = 0, fault_count = 0;
   int send_idle = 6, recv_idle = 66;
   int quiet_cycles = 0;

   function automatic logic [31:0] s16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] shr_s(input logic [31:0] x, input int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] div_s(input logic [31:0] a, input logic [31:0] b);
      longint q;
      q = longint'($signed(a)) / longint'($signed(b));
      return q[31:0];
   endfunction

   // compensation of one reading; updates the stored term and the ring
   function automatic reading_result_t compensate(input logic op, input logic [23:0] raw);
      reading_result_t r;
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, den, b6, sq, b3, b4, b7, p, up;
      logic [63:0] m;
      longint t;
      int unsigned k;
      ac1 = s16(cal_a[63:48]); ac2 = s16(cal_a[47:32]);
      ac3 = s16(cal_a[31:16]); ac4 = {16'd0, cal_a[15:0]};
      ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
      b1 = s16(cal_b[31:16]); b2 = s16(cal_b[15:0]);
      mc = s16(cal_c[31:16]); md = s16(cal_c[15:0]);
      k = oss_setting;
      r = '0;
      r.kind = op;
      if (op == OP_TEMP) begin
         x1 = shr_s(({16'd0, raw[15:0]} - ac6) * ac5, 15);
         den = x1 + md;
         if (den == 0) begin
            r.fault = 1'b1;
            b5_term = 0;
         end else begin
            b5_term = x1 + div_s(mc << 11, den);
            t = longint'($signed(shr_s(b5_term + 32'd8, 4)));
            if (t > 32767) t = 32767;
            if (t < -32768) t = -32768;
            r.temp = t[15:0];
         end
      end else begin
         up = {8'd0, raw} >> (8 - k);
         b6 = b5_term - 32'd4000;
         sq = shr_s(b6 * b6, 12);
         x1 = shr_s(b2 * sq, 11);
         x2 = shr_s(ac2 * b6, 11);
         x3 = x1 + x2;
         b3 = div_s(((ac1 * 32'd4 + x3) << k) + 32'd2, 32'd4);
         x1 = shr_s(ac3 * b6, 13);
         x2 = shr_s(b1 * sq, 16);
         x3 = shr_s(x1 + x2 + 32'd2, 2);
         m = {32'd0, ac4} * {32'd0, x3 + 32'd32768};
         b4 = m[31:0] >> 15;
         b7 = (up - b3) * (32'd50000 >> k);
         if (b4 == 0) begin
            r.fault = 1'b1;
         end else begin
            if (!b7[31]) p = (b7 * 32'd2) / b4;
            else p = (b7 / b4) * 32'd2;
            x1 = shr_s(p, 8) * shr_s(p, 8);
            x1 = shr_s(x1 * 32'd3038, 16);
            x2 = shr_s(32'hFFFF_E343 * p, 16);
            p = p + shr_s(x1 + x2 + 32'd3791, 4);
            t = longint'($signed(p));
            if (t < 0) t = 0;
            if (t > 1048575) t = 1048575;
            r.pres = t[19:0];
         end
         ring_total = ring_total - ring[ring_ptr] + r.pres;
         ring[ring_ptr] = r.pres;
         ring_ptr = (ring_ptr + 1 >= AVG_DEPTH) ? 0 : ring_ptr + 1;
      end
      r.avg = 20'(ring_total / AVG_DEPTH);
      return r;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CAL_A: cal_a = val;
         CSR_CAL_B: cal_b = val;
         CSR_CAL_C: cal_c = val[31:0];
         default:   oss_setting = val[1:0];
      endcase
   endtask

   // drop valid, wait until the block has drained, plus its longest latency
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // one request; idle gaps before it at the sender rate
   task automatic send_reading(input logic op, input logic [23:0] raw,
                               input logic typed, input reading_result_t res);
      reading_result_t pred;
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.raw_reading <= raw;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pred = compensate(op, raw);
      if (typed && pred !== res)
         $display("%0t table row mismatch: typed %h predicted %h", $time, res, pred);
      expected_results.push_back(typed ? res : pred);
      accepted++;
      if (op == OP_TEMP) temp_items++; else pres_items++;
      if (pred.fault) fault_count++;
   endtask

   // response checking and receiver stalls
   always @(posedge clock) begin
      reading_result_t got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.result_kind, rsp_ch.temperature_tenths, rsp_ch.pressure_pa,
                    rsp_ch.pressure_avg_pa, rsp_ch.divide_fault};
            if (expected_results.size() == 0) begin
               $display("%0t unexpected response: expected none actual %h", $time, got);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (got.kind !== want.kind) begin
                  $display("%0t kind: expected %0d actual %0d", $time, want.kind, got.kind);
                  errors++;
               end
               if (got.temp !== want.temp) begin
                  $display("%0t temp: expected %0d actual %0d", $time, want.temp, got.temp);
                  errors++;
               end
               if (got.pres !== want.pres) begin
                  $display("%0t pres: expected %0d actual %0d", $time, want.pres, got.pres);
                  errors++;
               end
               if (got.avg !== want.avg) begin
                  $display("%0t avg: expected %0d actual %0d", $time, want.avg, got.avg);
                  errors++;
               end
               if (got.fault !== want.fault) begin
                  $display("%0t fault: expected %0d actual %0d", $time, want.fault,
                           got.fault);
                  errors++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // typical calibration set of this sensor family
   localparam logic [63:0] CAL_A_TYP = {16'd408, -16'sd72, -16'sd14383, 16'd32741};
   localparam logic [63:0] CAL_B_TYP = {16'd32757, 16'd23153, 16'd6190, 16'd4};
   localparam logic [31:0] CAL_C_TYP = {-16'sd8711, 16'd2868};

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   initial begin
      stim_row_t rows[$];
      reading_result_t z;
      int phase;
      logic op;
      logic [23:0] raw;
      z = '0;
      req_ch.valid = 1'b0;
      req_ch.operation = OP_TEMP;
      req_ch.raw_reading = '0;
      cal_a = 0; cal_b = 0; cal_c = 0; oss_setting = 1;
      b5_term = 0; ring_ptr = 0; ring_total = 0;
      foreach (ring[i]) ring[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // after reset all calibration is zero: both divisors are zero
      rows.push_back('{OP_TEMP, 24'h000000, 1'b1, '{OP_TEMP, 16'sd0, 20'd0, 20'd0, 1'b1}});
      rows.push_back('{OP_TEMP, 24'hFFFFFF, 1'b1, '{OP_TEMP, 16'sd0, 20'd0, 20'd0, 1'b1}});
      rows.push_back('{OP_PRESS, 24'hFFFFFF, 1'b1, '{OP_PRESS, 16'sd0, 20'd0, 20'd0, 1'b1}});
      rows.push_back('{OP_PRESS, 24'h000000, 1'b1, '{OP_PRESS, 16'sd0, 20'd0, 20'd0, 1'b1}});
      foreach (rows[i]) send_reading(rows[i].op, rows[i].raw, rows[i].typed, rows[i].res);
      drain();

      // typical calibration, oversampling extremes
      write_reg(CSR_CAL_A, CAL_A_TYP);
      write_reg(CSR_CAL_B, CAL_B_TYP);
      write_reg(CSR_CAL_C, CAL_C_TYP);
      rows.delete();
      rows.push_back('{OP_TEMP, 24'h006C50, 1'b0, z});
      rows.push_back('{OP_PRESS, 24'h5D2300, 1'b0, z});
      rows.push_back('{OP_TEMP, 24'hFF0000, 1'b0, z});
      rows.push_back('{OP_TEMP, 24'h00FFFF, 1'b0, z});
      rows.push_back('{OP_PRESS, 24'hFFFFFF, 1'b0, z});
      rows.push_back('{OP_PRESS, 24'h000000, 1'b0, z});
      foreach (rows[i]) send_reading(rows[i].op, rows[i].raw, rows[i].typed, rows[i].res);
      drain();
      write_reg(CSR_OSS, 64'd0);
      send_reading(OP_PRESS, 24'h5D2300, 1'b0, z);
      send_reading(OP_PRESS, 24'hFFFFFF, 1'b0, z);
      drain();
      write_reg(CSR_OSS, 64'd3);
      send_reading(OP_PRESS, 24'h5D23C0, 1'b0, z);
      send_reading(OP_PRESS, 24'h000000, 1'b0, z);
      drain();
      // extreme calibration: all ones, then mc at most negative, md -1
      write_reg(CSR_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_CAL_B, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_CAL_C, 64'hFFFF_FFFF_FFFF_FFFF);
      send_reading(OP_TEMP, 24'h00FFFF, 1'b0, z);
      send_reading(OP_PRESS, 24'hFFFFFF, 1'b0, z);
      drain();
      write_reg(CSR_CAL_B, 64'h0000_FFFF_0000_0000);
      write_reg(CSR_CAL_C, {32'd0, 16'h8000, 16'hFFFF});
      send_reading(OP_TEMP, 24'h000000, 1'b0, z);
      send_reading(OP_PRESS, 24'h800000, 1'b0, z);
      drain();

      // random phases: idling pattern changes each third
      for (phase = 0; phase < 12; phase++) begin
         if (phase == 4) begin send_idle = 66; recv_idle = 6; end
         if (phase == 8) begin send_idle = 0; recv_idle = 0; end
         if (phase % 3 == 0) begin
            write_reg(CSR_CAL_A, rand64());
            write_reg(CSR_CAL_B, rand64());
            write_reg(CSR_CAL_C, {32'd0, $urandom});
         end else begin
            write_reg(CSR_CAL_A, CAL_A_TYP ^ {16'($urandom_range(255)), 48'd0});
            write_reg(CSR_CAL_B, CAL_B_TYP);
            write_reg(CSR_CAL_C, {32'd0, CAL_C_TYP ^ 32'($urandom_range(63))});
         end
         write_reg(CSR_OSS, {62'd0, 2'($urandom_range(3))});
         repeat (90) begin
            op = ($urandom_range(3) != 0) ? OP_PRESS : OP_TEMP;
            raw = ($urandom_range(3) == 0) ? 24'($urandom)
                  : (op == OP_TEMP ? 24'(24'h006000 + $urandom_range(16'h1FFF))
                                   : 24'(24'h500000 + $urandom_range(24'h1FFFFF)));
            send_reading(op, raw, 1'b0, z);
         end
         // sender holds off until every response is back
         drain();
      end

      drain();
      $display("Covered %0d requests (%0d temperature, %0d pressure, %0d divide faults)",
               accepted, temp_items, pres_items, fault_count);
      $display("over reset, typical, extreme and random calibration with all oversampling");
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/baro_pkg.sv
rtl/baro_ifs.sv
rtl/baro_dp.sv
rtl/baro_ctrl.sv
rtl/baro_compensation_averager.sv
rtl/baro_chk.sv
dv/baro_compensation_averager_tb.sv
